/* src/dual_wheel_speed_p_controller_top_macros.svh */
// Assertion shorthands for the speed controller checks.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef DUAL_WHEEL_SPEED_P_CONTROLLER_TOP_MACROS_SVH
`define DUAL_WHEEL_SPEED_P_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwsc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DWSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwsc: next-cycle check failed");

`endif

/* src/dwsc_pkg.sv */
`default_nettype none

package dwsc_pkg;

  localparam int LEVEL_W    = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL_INTERVAL = 3'd0,
    REG_GAIN_KP          = 3'd1,
    REG_MAX_LEVEL        = 3'd2,
    REG_MIN_LEVEL        = 3'd3,
    REG_MIN_EFFECTIVE    = 3'd4
  } reg_index_t;

  localparam logic [15:0]        RESET_CONTROL_INTERVAL = 16'd20;
  localparam logic [15:0]        RESET_GAIN_KP          = 16'd256;
  localparam logic [LEVEL_W-1:0] RESET_MAX_LEVEL        = 7'd100;
  localparam logic [LEVEL_W-1:0] RESET_MIN_LEVEL        = 7'd0;
  localparam logic [LEVEL_W-1:0] RESET_MIN_EFFECTIVE    = 7'd0;

  typedef struct packed {
    logic [15:0]        control_interval_ms;
    logic [15:0]        gain_kp;
    logic [LEVEL_W-1:0] max_level;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] min_effective_drive;
  } cfg_t;

  // Per-wheel command as classified by the front end. The step is the
  // proportional increment saturated to a range that still decides every clamp.
  typedef struct packed {
    logic                     zero;
    logic                     forward;
    logic signed [STEP_W-1:0] step;
  } wheel_cmd_t;

  typedef struct packed {
    logic        stop;
    logic [31:0] now_ms;
    wheel_cmd_t  left;
    wheel_cmd_t  right;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               forward;
    logic [LEVEL_W-1:0] drive;
  } wheel_state_t;

  typedef struct packed {
    logic               updated;
    logic               left_forward;
    logic [LEVEL_W-1:0] left_drive;
    logic               right_forward;
    logic [LEVEL_W-1:0] right_drive;
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
  } word_t;

endpackage

`default_nettype wire

/* src/dwsc_fifo.sv */
`default_nettype none

module dwsc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/dwsc_front.sv */
`default_nettype none

module dwsc_front #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dwsc_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic                          op,
  input  logic [31:0]                   now_ms,
  input  logic signed [SPEED_WIDTH-1:0] target_left,
  input  logic signed [SPEED_WIDTH-1:0] target_right,
  input  logic signed [SPEED_WIDTH-1:0] measured_left,
  input  logic signed [SPEED_WIDTH-1:0] measured_right,
  output logic                          cmd_push,
  input  logic                          cmd_full,
  output dwsc_pkg::cmd_t                cmd
);

  import dwsc_pkg::*;

  localparam int PROD_W = SPEED_WIDTH + 16;
  localparam int QUO_W  = PROD_W - 12;

  localparam logic [STEP_W-1:0] STEP_POS_SAT = 8'sd127;
  localparam logic [STEP_W-1:0] STEP_NEG_SAT = 8'h80;

  logic                   accept;
  logic [SPEED_WIDTH-1:0] tgt   [2];
  logic [SPEED_WIDTH-1:0] meas  [2];
  logic [SPEED_WIDTH-1:0] t_abs [2];
  logic [SPEED_WIDTH-1:0] m_abs [2];
  logic [SPEED_WIDTH:0]   diff  [2];

  logic                   s1_valid;
  logic                   s1_valid_next;
  logic                   s1_stop;
  logic [31:0]            s1_now;
  logic                   s1_zero [2];
  logic                   s1_fwd  [2];
  logic                   s1_neg  [2];
  logic [SPEED_WIDTH-1:0] s1_mag  [2];

  logic [PROD_W-1:0]      prod [2];
  logic [QUO_W-1:0]       quo  [2];
  logic [STEP_W-1:0]      step [2];

  assign tgt[0]  = target_left;
  assign tgt[1]  = target_right;
  assign meas[0] = measured_left;
  assign meas[1] = measured_right;

  assign full     = s1_valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = s1_valid && !cmd_full;

  // Speed difference |target| - |measured|, held as sign and magnitude.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      t_abs[w] = tgt[w][SPEED_WIDTH-1] ? (~tgt[w] + SPEED_WIDTH'(1)) : tgt[w];
      m_abs[w] = meas[w][SPEED_WIDTH-1] ? (~meas[w] + SPEED_WIDTH'(1)) : meas[w];
      diff[w]  = {1'b0, t_abs[w]} - {1'b0, m_abs[w]};
    end
  end

  assign s1_valid_next = accept || (s1_valid && cmd_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stop <= op;
      s1_now  <= now_ms;
      for (int w = 0; w < 2; w++) begin
        s1_zero[w] <= (tgt[w] == '0);
        s1_fwd[w]  <= !tgt[w][SPEED_WIDTH-1];
        s1_neg[w]  <= diff[w][SPEED_WIDTH];
        s1_mag[w]  <= diff[w][SPEED_WIDTH] ? (~diff[w][SPEED_WIDTH-1:0] + SPEED_WIDTH'(1))
                                           : diff[w][SPEED_WIDTH-1:0];
      end
    end
  end

  // Gain times error magnitude, truncated by 4096. Any step of 128 or more
  // already drives the level to a clamp bound, so it saturates there.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      prod[w] = PROD_W'(cfg.gain_kp) * PROD_W'(s1_mag[w]);
      quo[w]  = prod[w][PROD_W-1:12];
      if (s1_neg[w]) begin
        step[w] = (|quo[w][QUO_W-1:7]) ? STEP_NEG_SAT : (~{1'b0, quo[w][6:0]} + 8'd1);
      end else begin
        step[w] = (|quo[w][QUO_W-1:7]) ? STEP_POS_SAT : {1'b0, quo[w][6:0]};
      end
    end
  end

  always_comb begin
    cmd.stop          = s1_stop;
    cmd.now_ms        = s1_now;
    cmd.left.zero     = s1_zero[0];
    cmd.left.forward  = s1_fwd[0];
    cmd.left.step     = step[0];
    cmd.right.zero    = s1_zero[1];
    cmd.right.forward = s1_fwd[1];
    cmd.right.step    = step[1];
  end

endmodule

`default_nettype wire

/* src/dwsc_back.sv */
`default_nettype none

module dwsc_back (
  input  logic            clk,
  input  logic            rst,
  input  dwsc_pkg::cfg_t  cfg,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  dwsc_pkg::cmd_t  cmd,
  input  logic            word_full,
  output logic            word_push,
  output dwsc_pkg::word_t word
);

  import dwsc_pkg::*;

  function automatic wheel_state_t wheel_next(wheel_state_t cur, wheel_cmd_t c, cfg_t k);
    logic signed [LEVEL_W+1:0] sum;
    logic signed [LEVEL_W+1:0] max_s;
    logic signed [LEVEL_W+1:0] min_s;
    logic [LEVEL_W-1:0]        lvl;
    logic [LEVEL_W-1:0]        drv;
    wheel_state_t              res;
    sum   = $signed({2'b00, cur.level}) + $signed({c.step[STEP_W-1], c.step});
    max_s = $signed({2'b00, k.max_level});
    min_s = $signed({2'b00, k.min_level});
    if (sum <= 9'sd0) begin
      lvl = '0;
    end else if (sum >= max_s) begin
      lvl = k.max_level;
    end else if (sum < min_s) begin
      lvl = k.min_level;
    end else begin
      lvl = sum[LEVEL_W-1:0];
    end
    // Levels below the effective minimum snap to the nearer of 0 and that
    // minimum; a tie goes to 0.
    if (lvl == '0) begin
      drv = '0;
    end else if (lvl >= k.max_level) begin
      drv = k.max_level;
    end else if (lvl < k.min_effective_drive) begin
      drv = ({lvl, 1'b0} <= {1'b0, k.min_effective_drive}) ? '0 : k.min_effective_drive;
    end else begin
      drv = lvl;
    end
    if (c.zero) begin
      res.level   = '0;
      res.forward = 1'b1;
      res.drive   = '0;
    end else begin
      res.level   = lvl;
      res.forward = c.forward;
      res.drive   = drv;
    end
    return res;
  endfunction

  logic [31:0]  last_update_time;
  logic [31:0]  last_update_time_next;
  wheel_state_t left_state;
  wheel_state_t left_state_next;
  wheel_state_t right_state;
  wheel_state_t right_state_next;
  logic [31:0]  elapsed;
  logic         do_update;
  logic         go;

  assign go        = !cmd_empty && !word_full;
  assign cmd_pop   = go;
  assign word_push = go;

  assign elapsed   = cmd.now_ms - last_update_time;
  assign do_update = !cmd.stop && (elapsed >= {16'd0, cfg.control_interval_ms});

  always_comb begin
    last_update_time_next = last_update_time;
    left_state_next       = left_state;
    right_state_next      = right_state;
    if (cmd.stop) begin
      left_state_next  = '{level: '0, forward: 1'b1, drive: '0};
      right_state_next = '{level: '0, forward: 1'b1, drive: '0};
    end else if (do_update) begin
      last_update_time_next = cmd.now_ms;
      left_state_next       = wheel_next(left_state, cmd.left, cfg);
      right_state_next      = wheel_next(right_state, cmd.right, cfg);
    end
  end

  always_comb begin
    word.updated       = do_update;
    word.left_forward  = left_state_next.forward;
    word.left_drive    = left_state_next.drive;
    word.right_forward = right_state_next.forward;
    word.right_drive   = right_state_next.drive;
    word.left_level    = left_state_next.level;
    word.right_level   = right_state_next.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_update_time <= '0;
      left_state       <= '{level: '0, forward: 1'b1, drive: '0};
      right_state      <= '{level: '0, forward: 1'b1, drive: '0};
    end else if (go) begin
      last_update_time <= last_update_time_next;
      left_state       <= left_state_next;
      right_state      <= right_state_next;
    end
  end

endmodule

`default_nettype wire

/* src/dual_wheel_speed_p_controller_top.sv */
// A pushed word passes the front-end stage register, the command queue and the result queue to
// reach the result ports. Throughput: one word per cycle while results are popped, as
// every stage and queue moves a word per cycle; a full queue holds the stage ahead of it.
// Reset (rst, synchronous, active high) empties all queues, clears both levels, the last update
// time and the drives, sets both directions forward and loads the register defaults.
`default_nettype none

module dual_wheel_speed_p_controller_top #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input queue side.
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  op,
  input  logic [31:0]                           now_ms,
  input  logic signed [SPEED_WIDTH-1:0]         target_left,
  input  logic signed [SPEED_WIDTH-1:0]         target_right,
  input  logic signed [SPEED_WIDTH-1:0]         measured_left,
  input  logic signed [SPEED_WIDTH-1:0]         measured_right,
  // Result queue side.
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  updated,
  output logic                                  left_forward,
  output logic [dwsc_pkg::LEVEL_W-1:0]          left_drive,
  output logic                                  right_forward,
  output logic [dwsc_pkg::LEVEL_W-1:0]          right_drive,
  output logic [dwsc_pkg::LEVEL_W-1:0]          left_level,
  output logic [dwsc_pkg::LEVEL_W-1:0]          right_level,
  // Configuration write port.
  input  logic                                  cfg_write,
  input  logic [dwsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dwsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import dwsc_pkg::*;

  // The design splits into a front end and a back end. The front end
  // registers each word, forms |target| - |measured| for both wheels and
  // turns it into a saturated proportional step with one multiplier per
  // wheel. Classified commands wait in a two-entry queue. The back end
  // owns all controller state: it checks the update interval, applies the
  // steps, clamps the levels, snaps the drives and pushes one result word
  // per command into a two-entry output queue, so a single waiting result does
  // not block new input.

  cfg_t  cfg;
  cmd_t  front_cmd;
  cmd_t  back_cmd;
  word_t back_word;
  word_t out_word;
  logic  cmd_push;
  logic  cmd_full;
  logic  cmd_pop;
  logic  cmd_empty;
  logic  word_push;
  logic  word_full;

  // Register writes take effect at the edge; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_interval_ms <= RESET_CONTROL_INTERVAL;
      cfg.gain_kp             <= RESET_GAIN_KP;
      cfg.max_level           <= RESET_MAX_LEVEL;
      cfg.min_level           <= RESET_MIN_LEVEL;
      cfg.min_effective_drive <= RESET_MIN_EFFECTIVE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONTROL_INTERVAL: cfg.control_interval_ms <= cfg_data;
        REG_GAIN_KP:          cfg.gain_kp             <= cfg_data;
        REG_MAX_LEVEL:        cfg.max_level           <= cfg_data[LEVEL_W-1:0];
        REG_MIN_LEVEL:        cfg.min_level           <= cfg_data[LEVEL_W-1:0];
        REG_MIN_EFFECTIVE:    cfg.min_effective_drive <= cfg_data[LEVEL_W-1:0];
        default:              cfg                     <= cfg;
      endcase
    end
  end

  dwsc_front #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .op             (op),
    .now_ms         (now_ms),
    .target_left    (target_left),
    .target_right   (target_right),
    .measured_left  (measured_left),
    .measured_right (measured_right),
    .cmd_push       (cmd_push),
    .cmd_full       (cmd_full),
    .cmd            (front_cmd)
  );

  dwsc_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata (front_cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (back_cmd)
  );

  dwsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (back_cmd),
    .word_full (word_full),
    .word_push (word_push),
    .word      (back_word)
  );

  dwsc_fifo #(
    .WIDTH ($bits(word_t))
  ) u_word_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (word_push),
    .full  (word_full),
    .wdata (back_word),
    .pop   (pop),
    .empty (empty),
    .rdata (out_word)
  );

  assign updated       = out_word.updated;
  assign left_forward  = out_word.left_forward;
  assign left_drive    = out_word.left_drive;
  assign right_forward = out_word.right_forward;
  assign right_drive   = out_word.right_drive;
  assign left_level    = out_word.left_level;
  assign right_level   = out_word.right_level;

endmodule

`default_nettype wire

/* src/dwsc_checker.sv */
`default_nettype none
`include "dual_wheel_speed_p_controller_top_macros.svh"

module dwsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       updated,
  input logic       left_forward,
  input logic [6:0] left_drive,
  input logic       right_forward,
  input logic [6:0] right_drive,
  input logic [6:0] left_level,
  input logic [6:0] right_level
);

  logic [30:0] word_bits;

  assign word_bits = {updated, left_forward, left_drive, right_forward, right_drive,
                      left_level, right_level};

  // Leaving reset, no result is pending and input is open.
  `DWSC_ASSERT_NOW(a_reset_idle, $past(rst), empty && !full && !$past(push && !full))

  // A result that is not taken stays unchanged.
  `DWSC_ASSERT_NEXT(a_word_held, !empty && !pop, !empty && $stable(word_bits))

  // A wheel at level zero is never driven.
  `DWSC_ASSERT_NOW(a_left_idle_drive, !empty && (left_level == 7'd0), left_drive == 7'd0)
  `DWSC_ASSERT_NOW(a_right_idle_drive, !empty && (right_level == 7'd0), right_drive == 7'd0)

endmodule

bind dual_wheel_speed_p_controller_top dwsc_checker u_dwsc_checker (.*);

`default_nettype wire
